// ===== src/ils_pkg.sv =====
// Shared types and constants of the integer list sorter.
package ils_pkg;

    localparam int ILS_MAX_ITEMS  = 64;
    localparam int ILS_DATA_WIDTH = 32;
    localparam int ILS_WIDE_W     = 64;   // widest element the sorter supports
    localparam int ILS_FIELD_W    = 32;   // value field width on the stream ports
    localparam int ILS_CFG_IDX_W  = 2;

    localparam logic [ILS_CFG_IDX_W-1:0] ILS_REG_ASCENDING = 2'd0;
    localparam logic [ILS_CFG_IDX_W-1:0] ILS_REG_SIGNED    = 2'd1;

    // Command broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic shift;       // every cell takes its upper neighbor
        logic sort;        // odd-even compare-and-swap round
        logic round_odd;   // pairs start at odd cells in this round
        logic ascending;   // smallest first
        logic signed_cmp;  // two's complement compare
    } ils_ctrl_t;

endpackage

// ===== src/ils_cell.sv =====
// One storage cell of the sorting chain: holds one element, swaps with its upper neighbor.
module ils_cell import ils_pkg::*; #(
    parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ils_ctrl_t             ctrl,
    input  logic                  cell_odd,
    input  logic                  up_valid,
    input  logic [DATA_WIDTH-1:0] up_value,
    input  logic [DATA_WIDTH-1:0] dn_value,
    input  logic                  swap_in,
    output logic                  swap_out,
    output logic                  valid,
    output logic [DATA_WIDTH-1:0] value
);

    localparam logic [DATA_WIDTH-1:0] SIGN_MASK = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic [DATA_WIDTH-1:0] key_flip;
    logic [DATA_WIDTH-1:0] own_key;
    logic [DATA_WIDTH-1:0] up_key;
    logic                  goes_after;
    logic                  is_lower;

    assign key_flip   = ctrl.signed_cmp ? SIGN_MASK : '0;
    assign own_key    = value_reg ^ key_flip;
    assign up_key     = up_value ^ key_flip;
    assign goes_after = ctrl.ascending ? (own_key > up_key) : (own_key < up_key);
    assign is_lower   = (cell_odd == ctrl.round_odd);

    // Swap only on a strict order violation so equal elements keep their load order.
    assign swap_out = ctrl.sort && is_lower && valid_reg && up_valid && goes_after;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift) begin
            valid_next = up_valid;
            value_next = up_value;
        end else if (swap_out) begin
            value_next = up_value;
        end else if (ctrl.sort && !is_lower && swap_in) begin
            value_next = dn_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

// ===== src/ils_chain.sv =====
// Row of sorting cells; elements enter at the top and leave at cell zero.
module ils_chain import ils_pkg::*; #(
    parameter int MAX_ITEMS  = ILS_MAX_ITEMS,
    parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ils_ctrl_t             ctrl,
    input  logic                  head_valid,
    input  logic [DATA_WIDTH-1:0] head_value,
    output logic                  tail_valid,
    output logic [DATA_WIDTH-1:0] tail_value
);

    logic                  valid_w [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] value_w [MAX_ITEMS];
    logic                  swap_w  [MAX_ITEMS];
    logic                  up_valid_w [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] up_value_w [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] dn_value_w [MAX_ITEMS];
    logic                  swap_in_w  [MAX_ITEMS];

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        if (i == MAX_ITEMS - 1) begin : g_top
            assign up_valid_w[i] = head_valid;
            assign up_value_w[i] = head_value;
        end else begin : g_mid
            assign up_valid_w[i] = valid_w[i+1];
            assign up_value_w[i] = value_w[i+1];
        end
        if (i == 0) begin : g_bottom
            assign dn_value_w[i] = '0;
            assign swap_in_w[i]  = 1'b0;
        end else begin : g_above
            assign dn_value_w[i] = value_w[i-1];
            assign swap_in_w[i]  = swap_w[i-1];
        end

        ils_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .cell_odd ((i % 2) == 1),
            .up_valid (up_valid_w[i]),
            .up_value (up_value_w[i]),
            .dn_value (dn_value_w[i]),
            .swap_in  (swap_in_w[i]),
            .swap_out (swap_w[i]),
            .valid    (valid_w[i]),
            .value    (value_w[i])
        );
    end

    assign tail_valid = valid_w[0];
    assign tail_value = value_w[0];

endmodule

// ===== src/integer_list_sorter.sv =====
// Top level of the integer list sorter: stream ports, config registers and sequencer.
//
//  channel  | direction | signals                          | contents
//  s_       | in        | s_tvalid s_tready s_tdata s_tlast | one list element, tlast ends list
//  m_       | out       | m_tvalid m_tready m_tdata m_tlast | sorted elements, tuser = dropped
//           |           | m_tuser                          |
//  cfg_     | in        | cfg_wr_en cfg_index cfg_wr_data  | register writes, no read-back
//
// Loading takes one beat per cycle. After the last beat of a list the chain first moves
// the list down to cell zero, then runs odd-even compare-and-swap rounds, then emits
// one beat per cycle. s_tready is low from the last input beat until the last output
// beat; m_tready low holds the chain.
// Reset clears the chain, the counters and loads the register defaults.
module integer_list_sorter import ils_pkg::*; #(
    parameter int MAX_ITEMS  = ILS_MAX_ITEMS,
    parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [ILS_FIELD_W-1:0]   s_tdata,   // [31:0] value
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ILS_FIELD_W-1:0]   m_tdata,   // [31:0] sorted_value
    output logic                     m_tlast,
    output logic                     m_tuser,   // [0] items_dropped
    input  logic                     cfg_wr_en,
    input  logic [ILS_CFG_IDX_W-1:0] cfg_index,
    input  logic                     cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_SORT  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] round_reg, round_next;
    logic             ovf_reg, ovf_next;
    logic             ascending_reg;
    logic             signed_reg;

    ils_ctrl_t             ctrl;
    logic                  in_beat;
    logic                  out_beat;
    logic                  room;
    logic                  tail_valid;
    logic [DATA_WIDTH-1:0] tail_value;
    logic [DATA_WIDTH-1:0] head_value;
    logic [ILS_WIDE_W-1:0] in_wide;
    logic [ILS_WIDE_W-1:0] out_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ascending_reg <= 1'b0;
            signed_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ILS_REG_ASCENDING: ascending_reg <= cfg_wr_data;
                ILS_REG_SIGNED:    signed_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT) && tail_valid;
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign room     = (count_reg != CNT_FULL);

    // keep only the low DATA_WIDTH bits of the element
    assign in_wide    = {{(ILS_WIDE_W-ILS_FIELD_W){1'b0}}, s_tdata};
    assign head_value = in_wide[DATA_WIDTH-1:0];
    assign out_wide   = ILS_WIDE_W'(tail_value);
    assign m_tdata    = out_wide[ILS_FIELD_W-1:0];
    assign m_tlast    = (count_reg == CNT_ONE);
    assign m_tuser    = ovf_reg;

    always_comb begin
        ctrl.shift      = (in_beat && room)
                        || (state_reg == ST_ALIGN && !tail_valid)
                        || out_beat;
        ctrl.sort       = (state_reg == ST_SORT);
        ctrl.round_odd  = round_reg[0];
        ctrl.ascending  = ascending_reg;
        ctrl.signed_cmp = signed_reg;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    if (room) begin
                        count_next = count_reg + CNT_ONE;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_ALIGN;
                        round_next = '0;
                    end
                end
            end
            ST_ALIGN: begin
                if (tail_valid) begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                round_next = round_reg + CNT_ONE;
                if (round_reg == count_reg - CNT_ONE) begin
                    state_next = ST_EMIT;
                    round_next = '0;
                end
            end
            ST_EMIT: begin
                if (out_beat) begin
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE) begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            round_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            ovf_reg   <= ovf_next;
        end
    end

    ils_chain #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .head_valid (state_reg == ST_LOAD),
        .head_value (head_value),
        .tail_valid (tail_valid),
        .tail_value (tail_value)
    );

endmodule

// ===== test/integer_list_sorter_tb.sv =====
// Self-checking testbench for integer_list_sorter: random lists, stalls and register settings.
module integer_list_sorter_tb;
    import ils_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ELEMENT_GOAL = 450;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          DRAIN_CYCLES = 2 * ILS_MAX_ITEMS + 16;

    // Indexes that decode to no register; writes there must change nothing.
    localparam logic [ILS_CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [ILS_CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef logic [ILS_FIELD_W-1:0]    field_t;
    typedef logic [ILS_DATA_WIDTH-1:0] element_t;

    // Holds the list being loaded and the sorted beats still owed by the block.
    class list_sort_model;
        typedef struct packed {
            field_t value;
            logic   last;
            logic   dropped;
        } sorted_beat_t;

        element_t     held[$];
        bit           overflow;
        bit           ascending;
        bit           signed_cmp;
        sorted_beat_t sorted_pending[$];
        int           mismatches;
        int           beats_checked;
        int           lists_closed;
        int           lists_with_drops;

        function new();
            ascending  = 1'b0;
            signed_cmp = 1'b1;
        endfunction

        function void write_reg(logic [ILS_CFG_IDX_W-1:0] idx, logic data);
            case (idx)
                ILS_REG_ASCENDING: ascending = data;
                ILS_REG_SIGNED:    signed_cmp = data;
                default: ;
            endcase
        endfunction

        // Flip the sign bit so signed order becomes plain unsigned order.
        function element_t order_key(element_t v);
            return signed_cmp ? (v ^ {1'b1, {(ILS_DATA_WIDTH-1){1'b0}}}) : v;
        endfunction

        function bit goes_after(element_t a, element_t b);
            return ascending ? (order_key(a) > order_key(b)) : (order_key(a) < order_key(b));
        endfunction

        function void take_element(field_t value, logic last);
            element_t     cur;
            int           j;
            sorted_beat_t beat;
            if (held.size() < ILS_MAX_ITEMS)
                held.push_back(value[ILS_DATA_WIDTH-1:0]);
            else
                overflow = 1'b1;
            if (!last)
                return;
            // insertion sort keeps equal keys in load order
            for (int i = 1; i < held.size(); i++) begin
                cur = held[i];
                j = i;
                while (j > 0 && goes_after(held[j-1], cur)) begin
                    held[j] = held[j-1];
                    j--;
                end
                held[j] = cur;
            end
            foreach (held[k]) begin
                beat.value   = field_t'(held[k]);
                beat.last    = (k == held.size() - 1);
                beat.dropped = overflow;
                sorted_pending.push_back(beat);
            end
            lists_closed++;
            if (overflow)
                lists_with_drops++;
            held.delete();
            overflow = 1'b0;
        endfunction

        task report_mismatch(string what);
            if (mismatches < 25)
                $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task compare_sorted_beat(field_t value, logic last, logic dropped);
            sorted_beat_t want;
            beats_checked++;
            if (sorted_pending.size() == 0) begin
                report_mismatch($sformatf("beat %h with nothing outstanding", value));
                return;
            end
            want = sorted_pending.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %h, want %h", value, want.value));
            if (last !== want.last)
                report_mismatch($sformatf("tlast %b, want %b", last, want.last));
            if (dropped !== want.dropped)
                report_mismatch($sformatf("dropped flag %b, want %b", dropped, want.dropped));
        endtask

        function int pending();
            return sorted_pending.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [ILS_FIELD_W-1:0]   s_tdata;   // [31:0] value
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [ILS_FIELD_W-1:0]   m_tdata;   // [31:0] sorted_value
    logic                     m_tlast;
    logic                     m_tuser;   // [0] items_dropped
    logic                     cfg_wr_en;
    logic [ILS_CFG_IDX_W-1:0] cfg_index;
    logic                     cfg_wr_data;

    list_sort_model model;
    bit             gaps_on;
    bit [3:0]       settings_seen;
    int             elements_sent;
    int unsigned    cycle_count;
    int             stall_left;

    integer_list_sorter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, model.pending());
            $display("integer_list_sorter_tb NOT OK");
            $finish;
        end
    end

    // Mostly no gap, some short, a few long.
    function int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: check accepted beats, then pick next cycle's tready.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                model.compare_sorted_beat(m_tdata, m_tlast, m_tuser);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    function field_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return $urandom;
            4: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            // small values around zero: many ties and sign crossings
            5, 6: return field_t'($urandom_range(0, 15)) - 8;
            default: return {$urandom_range(0, 3) == 0 ? 1'b1 : 1'b0, 31'($urandom)};
        endcase
    endfunction

    task send_element(field_t value, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        model.take_element(value, last);
        elements_sent++;
    endtask

    task send_list(field_t values[$]);
        settings_seen[{model.ascending, model.signed_cmp}] = 1'b1;
        foreach (values[i])
            send_element(values[i], i == values.size() - 1);
    endtask

    task send_random_list(int len);
        field_t values[$];
        repeat (len) values.push_back(pick_value());
        send_list(values);
    endtask

    // Registers change only with the sorter idle.
    task settle();
        // drop tvalid so the finished list's last beat is not taken again
        s_tvalid <= 1'b0;
        while (model.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task apply_settings(bit ascending, bit signed_cmp, bit poke_spare);
        logic [ILS_CFG_IDX_W-1:0] idx[$];
        logic                     val[$];
        idx = '{ILS_REG_ASCENDING, ILS_REG_SIGNED};
        val = '{ascending, signed_cmp};
        if (poke_spare) begin
            idx.push_back($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI);
            val.push_back(1'($urandom));
        end
        settle();
        foreach (idx[i]) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge aclk);
            model.write_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 12);
        if (r < 85)
            return $urandom_range(13, ILS_MAX_ITEMS - 1);
        if (r < 93)
            return ILS_MAX_ITEMS;
        return $urandom_range(ILS_MAX_ITEMS + 1, ILS_MAX_ITEMS + 8);
    endfunction

    initial begin
        field_t extremes[$];
        model         = new();
        gaps_on       = 1'b0;
        settings_seen = '0;
        elements_sent = 0;
        cycle_count   = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = ILS_REG_ASCENDING;
        cfg_wr_data   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings are largest first, signed
        extremes = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0001};
        send_list('{32'h8000_0000});
        send_list(extremes);
        apply_settings(1'b1, 1'b0, 1'b1);
        send_list(extremes);
        apply_settings(1'b1, 1'b1, 1'b0);
        send_list('{32'hFFFF_FFFF, 32'h0000_0001});
        apply_settings(1'b0, 1'b0, 1'b1);
        send_list('{32'hFFFF_FFFF, 32'h0000_0001});

        // random: start with an overflowing list and a full one
        gaps_on = 1'b1;
        send_random_list(ILS_MAX_ITEMS + 2);
        send_random_list(ILS_MAX_ITEMS);
        while (elements_sent < ELEMENT_GOAL) begin
            if ($urandom_range(0, 99) < 30)
                apply_settings(1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
            gaps_on = ($urandom_range(0, 99) < 80);
            send_random_list(pick_length());
        end
        s_tvalid <= 1'b0;

        while (model.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (model.held.size() != 0 || model.pending() != 0)
            model.report_mismatch($sformatf("%0d beats never arrived", model.pending()));
        $display("covered %0d lists (%0d over capacity), %0d elements in, %0d sorted beats out",
                 model.lists_closed, model.lists_with_drops, elements_sent,
                 model.beats_checked);
        $display("order/compare settings exercised (bit = {ascending, signed}): %b",
                 settings_seen);
        if (model.mismatches == 0) begin
            $display("integer_list_sorter_tb OK");
        end else begin
            $display("integer_list_sorter_tb NOT OK");
        end
        $finish;
    end

endmodule
